FILE: rtl/srmt_pkg.sv
// Shared types and constants for the staged range merge table.
// Holds table sizing, beat layouts, status codes, FSM states and ctrl/dpath structs.
// No dependencies.
`timescale 1ns / 1ps

package srmt_pkg;

  // Table sizing
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int OFS_W         = 63;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 5;

  // Beat layouts
  localparam int IN_TDATA_W  = ((2 * OFS_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_TDATA_W - 2 * OFS_W;
  localparam int OUT_TDATA_W = ((2 * OFS_W + ENTRY_COUNT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * OFS_W - ENTRY_COUNT_W;
  localparam int OUT_TUSER_W = STATUS_W + 1;

  // Opcodes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_REC_RD,
    S_REC_EV,
    S_REC_CP,
    S_REC_TAIL,
    S_QRY_RD,
    S_QRY_EV,
    S_QRY_FIN,
    S_RESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;        // latch the input beat, clear scan counters
    logic    rd_en;       // read entry i of the live bank
    logic    wr_new;      // write the working range at slot n of the shadow bank
    logic    wr_old;      // write the last read entry at slot n of the shadow bank
    logic    merge;       // widen the working range over the last read entry
    logic    inc_i;       // advance the scan index
    logic    commit;      // swap banks and take the new count
    logic    set_status;  // capture status for the final result
    status_t status;
    logic    take_pend;   // hold the clipped overlap as pending hit
    logic    emit_pend;   // send the pending hit
    logic    emit_last;   // pending hit is the final result of the item
    logic    emit_final;  // send the single closing result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_query;
    logic empty;       // end <= start
    logic scan_end;    // scan index reached the stored count
    logic placed;      // working range already written this pass
    logic full;        // new table already holds TABLE_DEPTH entries
    logic before_new;  // working range lies wholly before the read entry
    logic after_old;   // working range lies wholly after the read entry
    logic q_stop;      // read entry starts at or past the window end
    logic q_skip;      // read entry ends at or before the window start
    logic pend_valid;
    logic slot_free;   // output register can take a beat this cycle
  } sts_t;

endpackage

FILE: rtl/srmt_dpath.sv
// Datapath of the staged range merge table: ping-pong range banks, scan
// registers, pending hit and output register. Driven by srmt_ctrl; uses srmt_pkg.
`timescale 1ns / 1ps

module srmt_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  srmt_pkg::cmd_t                       cmd,
  output srmt_pkg::sts_t                       sts,
  input  logic                                 in_op,
  input  logic [srmt_pkg::OFS_W-1:0]           in_start,
  input  logic [srmt_pkg::OFS_W-1:0]           in_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [srmt_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_hit,
  output logic [srmt_pkg::OFS_W-1:0]           out_seg_start,
  output logic [srmt_pkg::OFS_W-1:0]           out_seg_end,
  output logic [srmt_pkg::ENTRY_COUNT_W-1:0]   out_count,
  output logic                                 out_last
);

  // Two banks: one live, one being rebuilt by a record pass
  logic [srmt_pkg::OFS_W-1:0] mem_start [0:1][0:srmt_pkg::TABLE_DEPTH-1];
  logic [srmt_pkg::OFS_W-1:0] mem_end   [0:1][0:srmt_pkg::TABLE_DEPTH-1];

  logic                           op_r;
  logic [srmt_pkg::OFS_W-1:0]     s_r, s_nxt;
  logic [srmt_pkg::OFS_W-1:0]     e_r, e_nxt;
  logic [srmt_pkg::OFS_W-1:0]     rd_s_r, rd_e_r;
  logic [srmt_pkg::OFS_W-1:0]     pend_s_r, pend_e_r;
  logic [srmt_pkg::CNT_W-1:0]     i_r, n_r, n_nxt, count_r;
  logic                           placed_r, pend_valid_r, bank_r;
  srmt_pkg::status_t              status_r;
  logic                           wr_en;
  logic [srmt_pkg::OFS_W-1:0]     wr_s, wr_e;
  logic [srmt_pkg::OFS_W-1:0]     clip_s, clip_e;

  logic                                out_valid_r;
  logic [srmt_pkg::STATUS_W-1:0]       out_status_r;
  logic                                out_hit_r, out_last_r;
  logic [srmt_pkg::OFS_W-1:0]          out_seg_start_r, out_seg_end_r;
  logic [srmt_pkg::ENTRY_COUNT_W-1:0]  out_count_r;
  logic                                slot_free;

  // Status toward the controller
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    sts.is_query   = (op_r == srmt_pkg::OP_QUERY);
    sts.empty      = (e_r <= s_r);
    sts.scan_end   = (i_r == count_r);
    sts.placed     = placed_r;
    sts.full       = (n_r == srmt_pkg::CNT_W'(srmt_pkg::TABLE_DEPTH));
    sts.before_new = (e_r < rd_s_r);
    sts.after_old  = (s_r > rd_e_r);
    sts.q_stop     = (rd_s_r >= e_r);
    sts.q_skip     = (rd_e_r <= s_r);
    sts.pend_valid = pend_valid_r;
    sts.slot_free  = slot_free;
  end

  // Working range: widen on merge
  always_comb begin
    s_nxt = s_r;
    e_nxt = e_r;
    if (cmd.merge) begin
      if (rd_s_r < s_r) s_nxt = rd_s_r;
      if (rd_e_r > e_r) e_nxt = rd_e_r;
    end
  end

  // Clip the read entry to the window
  assign clip_s = (rd_s_r > s_r) ? rd_s_r : s_r;
  assign clip_e = (rd_e_r < e_r) ? rd_e_r : e_r;

  // Shadow bank write
  assign wr_en = cmd.wr_new || cmd.wr_old;
  assign wr_s  = cmd.wr_new ? s_r : rd_s_r;
  assign wr_e  = cmd.wr_new ? e_r : rd_e_r;
  assign n_nxt = wr_en ? n_r + 1'b1 : n_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[~bank_r][n_r[srmt_pkg::IDX_W-1:0]] <= wr_s;
      mem_end[~bank_r][n_r[srmt_pkg::IDX_W-1:0]]   <= wr_e;
    end
    if (cmd.rd_en) begin
      rd_s_r <= mem_start[bank_r][i_r[srmt_pkg::IDX_W-1:0]];
      rd_e_r <= mem_end[bank_r][i_r[srmt_pkg::IDX_W-1:0]];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op;
      s_r  <= in_start;
      e_r  <= in_end;
    end else begin
      s_r <= s_nxt;
      e_r <= e_nxt;
    end
    if (cmd.take_pend) begin
      pend_s_r <= clip_s;
      pend_e_r <= clip_e;
    end
    if (cmd.set_status) status_r <= cmd.status;
  end

  // Scan control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r          <= '0;
      n_r          <= '0;
      placed_r     <= 1'b0;
      pend_valid_r <= 1'b0;
      bank_r       <= 1'b0;
      count_r      <= '0;
    end else begin
      if (cmd.load) begin
        i_r          <= '0;
        n_r          <= '0;
        placed_r     <= 1'b0;
        pend_valid_r <= 1'b0;
      end else begin
        if (cmd.inc_i) i_r <= i_r + 1'b1;
        n_r <= n_nxt;
        if (cmd.wr_new) placed_r <= 1'b1;
        if (cmd.take_pend) begin
          pend_valid_r <= 1'b1;
        end else if (cmd.emit_pend && cmd.emit_last) begin
          pend_valid_r <= 1'b0;
        end
      end
      if (cmd.commit) begin
        bank_r  <= ~bank_r;
        count_r <= n_nxt;
      end
    end
  end

  // Output register: valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_final || cmd.emit_pend) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (cmd.emit_final) begin
      out_status_r    <= status_r;
      out_hit_r       <= 1'b0;
      out_seg_start_r <= '0;
      out_seg_end_r   <= '0;
      out_count_r     <= srmt_pkg::ENTRY_COUNT_W'(count_r);
      out_last_r      <= 1'b1;
    end else if (cmd.emit_pend) begin
      out_status_r    <= srmt_pkg::ST_DONE;
      out_hit_r       <= 1'b1;
      out_seg_start_r <= pend_s_r;
      out_seg_end_r   <= pend_e_r;
      out_count_r     <= srmt_pkg::ENTRY_COUNT_W'(count_r);
      out_last_r      <= cmd.emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_hit       = out_hit_r;
  assign out_seg_start = out_seg_start_r;
  assign out_seg_end   = out_seg_end_r;
  assign out_count     = out_count_r;
  assign out_last      = out_last_r;

endmodule

FILE: rtl/srmt_ctrl.sv
// Sequencer of the staged range merge table: walks the stored ranges for
// record and query items and issues commands to srmt_dpath. Uses srmt_pkg.
`timescale 1ns / 1ps

module srmt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  srmt_pkg::sts_t sts,
  output srmt_pkg::cmd_t cmd
);

  srmt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srmt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srmt_pkg::S_IDLE: begin
        if (in_valid) state_nxt = srmt_pkg::S_CHECK;
      end
      srmt_pkg::S_CHECK: begin
        if (sts.empty) state_nxt = srmt_pkg::S_RESP;
        else if (sts.is_query) state_nxt = srmt_pkg::S_QRY_RD;
        else state_nxt = srmt_pkg::S_REC_RD;
      end
      srmt_pkg::S_REC_RD: begin
        state_nxt = sts.scan_end ? srmt_pkg::S_REC_TAIL : srmt_pkg::S_REC_EV;
      end
      srmt_pkg::S_REC_EV: begin
        if (!sts.placed && sts.before_new) begin
          state_nxt = sts.full ? srmt_pkg::S_RESP : srmt_pkg::S_REC_CP;
        end else if (sts.placed || sts.after_old) begin
          state_nxt = sts.full ? srmt_pkg::S_RESP : srmt_pkg::S_REC_RD;
        end else begin
          state_nxt = srmt_pkg::S_REC_RD;
        end
      end
      srmt_pkg::S_REC_CP: begin
        state_nxt = sts.full ? srmt_pkg::S_RESP : srmt_pkg::S_REC_RD;
      end
      srmt_pkg::S_REC_TAIL: begin
        state_nxt = srmt_pkg::S_RESP;
      end
      srmt_pkg::S_QRY_RD: begin
        state_nxt = sts.scan_end ? srmt_pkg::S_QRY_FIN : srmt_pkg::S_QRY_EV;
      end
      srmt_pkg::S_QRY_EV: begin
        if (sts.q_stop) state_nxt = srmt_pkg::S_QRY_FIN;
        else if (sts.q_skip) state_nxt = srmt_pkg::S_QRY_RD;
        else if (!sts.pend_valid || sts.slot_free) state_nxt = srmt_pkg::S_QRY_RD;
      end
      srmt_pkg::S_QRY_FIN: begin
        if (!sts.pend_valid) state_nxt = srmt_pkg::S_RESP;
        else if (sts.slot_free) state_nxt = srmt_pkg::S_IDLE;
      end
      srmt_pkg::S_RESP: begin
        if (sts.slot_free) state_nxt = srmt_pkg::S_IDLE;
      end
      default: state_nxt = srmt_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd        = '0;
    cmd.status = srmt_pkg::ST_DONE;
    in_ready   = 1'b0;
    case (state_r)
      srmt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      srmt_pkg::S_CHECK: begin
        if (sts.empty) begin
          cmd.set_status = 1'b1;
          cmd.status     = srmt_pkg::ST_EMPTY;
        end
      end
      srmt_pkg::S_REC_RD: begin
        cmd.rd_en = !sts.scan_end;
      end
      srmt_pkg::S_REC_EV: begin
        if ((!sts.placed && sts.before_new) || sts.placed || sts.after_old) begin
          if (sts.full) begin
            cmd.set_status = 1'b1;
            cmd.status     = srmt_pkg::ST_FULL;
          end else if (!sts.placed && sts.before_new) begin
            cmd.wr_new = 1'b1;
          end else begin
            cmd.wr_old = 1'b1;
            cmd.inc_i  = 1'b1;
          end
        end else begin
          cmd.merge = 1'b1;
          cmd.inc_i = 1'b1;
        end
      end
      srmt_pkg::S_REC_CP: begin
        if (sts.full) begin
          cmd.set_status = 1'b1;
          cmd.status     = srmt_pkg::ST_FULL;
        end else begin
          cmd.wr_old = 1'b1;
          cmd.inc_i  = 1'b1;
        end
      end
      srmt_pkg::S_REC_TAIL: begin
        cmd.set_status = 1'b1;
        if (!sts.placed && sts.full) begin
          cmd.status = srmt_pkg::ST_FULL;
        end else begin
          cmd.status = srmt_pkg::ST_DONE;
          cmd.wr_new = !sts.placed;
          cmd.commit = 1'b1;
        end
      end
      srmt_pkg::S_QRY_RD: begin
        cmd.rd_en = !sts.scan_end;
      end
      srmt_pkg::S_QRY_EV: begin
        // An entry at or past the window end stops the scan with no command
        if (!sts.q_stop && sts.q_skip) begin
          cmd.inc_i = 1'b1;
        end else if (!sts.q_stop && (!sts.pend_valid || sts.slot_free)) begin
          // Flush the previous hit as a middle beat, keep the new one
          cmd.emit_pend = sts.pend_valid;
          cmd.take_pend = 1'b1;
          cmd.inc_i     = 1'b1;
        end
      end
      srmt_pkg::S_QRY_FIN: begin
        if (!sts.pend_valid) begin
          cmd.set_status = 1'b1;
          cmd.status     = srmt_pkg::ST_DONE;
        end else if (sts.slot_free) begin
          cmd.emit_pend = 1'b1;
          cmd.emit_last = 1'b1;
        end
      end
      srmt_pkg::S_RESP: begin
        cmd.emit_final = sts.slot_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/staged_range_merge_table_core.sv
// Top level of the staged range merge table: stream ports, beat packing,
// and the srmt_ctrl / srmt_dpath pair. Uses srmt_pkg.
//
//   channel | direction | beat content
//   in_     | slave     | tuser: opcode; tdata: range_start, range_end
//   out_    | master    | tuser: status, hit; tdata: seg_start, seg_end, entry_count; tlast
//
// A record walks the N stored ranges with one read and one evaluate state per entry,
// one copy state more when the new range slots in ahead of a stored one, then a tail
// state and its result beat; a refused record stops early, an empty one skips the scan.
// A query reads and evaluates the entries up to the window end, then closes the item;
// each hit beat waits for a free output register.
// One item is in work at a time; in_tready rises in the same cycle that the last result
// appears in the output register. Reset clears the table count and all control state.
`timescale 1ns / 1ps

module staged_range_merge_table_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [srmt_pkg::IN_TDATA_W-1:0]     in_tdata,   // range_start, range_end, pad
  input  logic                                in_tuser,   // opcode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [srmt_pkg::OUT_TDATA_W-1:0]    out_tdata,  // seg_start, seg_end, entry_count, pad
  output logic [srmt_pkg::OUT_TUSER_W-1:0]    out_tuser,  // status, hit
  output logic                                out_tlast
);

  srmt_pkg::cmd_t cmd;
  srmt_pkg::sts_t sts;

  logic [srmt_pkg::STATUS_W-1:0]       res_status;
  logic                                res_hit;
  logic [srmt_pkg::OFS_W-1:0]          res_seg_start, res_seg_end;
  logic [srmt_pkg::ENTRY_COUNT_W-1:0]  res_count;

  srmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srmt_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_tuser),
    .in_start      (in_tdata[srmt_pkg::OFS_W-1:0]),
    .in_end        (in_tdata[2*srmt_pkg::OFS_W-1:srmt_pkg::OFS_W]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_status    (res_status),
    .out_hit       (res_hit),
    .out_seg_start (res_seg_start),
    .out_seg_end   (res_seg_end),
    .out_count     (res_count),
    .out_last      (out_tlast)
  );

  // Pack the result beat
  assign out_tdata = {{srmt_pkg::OUT_PAD_W{1'b0}}, res_count, res_seg_end, res_seg_start};
  assign out_tuser = {res_hit, res_status};

endmodule

FILE: rtl/srmt_checker.sv
// Port-level checks for staged_range_merge_table_core, attached by bind.
// Uses srmt_pkg for beat layout and status codes.
`timescale 1ns / 1ps

module srmt_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [srmt_pkg::OUT_TUSER_W-1:0]    out_tuser,
  input logic                                out_tlast
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // Input side goes busy after each accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous item in work");

  // A result without a hit always closes its item
  a_nohit_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[srmt_pkg::STATUS_W] |-> out_tlast)
    else $error("no-hit result without last");

  // Empty or refused results are single no-hit beats
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[srmt_pkg::STATUS_W-1:0] != srmt_pkg::ST_DONE)
    |-> out_tlast && !out_tuser[srmt_pkg::STATUS_W])
    else $error("error status on a hit or middle beat");

  // Only the three defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[srmt_pkg::STATUS_W-1:0] == srmt_pkg::ST_DONE) ||
                   (out_tuser[srmt_pkg::STATUS_W-1:0] == srmt_pkg::ST_EMPTY) ||
                   (out_tuser[srmt_pkg::STATUS_W-1:0] == srmt_pkg::ST_FULL))
    else $error("undefined status code");

endmodule

bind staged_range_merge_table_core srmt_checker u_srmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
